@@ design/tkws_pkg.sv @@
// tkws_pkg: shared widths, constants and the job record of the top-k token sampler
// used by every module of the sampler; depends on nothing else

package tkws_pkg;

   localparam int MAX_ITEMS    = 128;
   localparam int TOP_SLOTS    = 8;
   localparam int QUEUE_DEPTH  = 2;

   localparam int LOGIT_W      = 32;
   localparam int SEED_W       = 16;
   localparam int POS_W        = 7;
   localparam int TOP_K_W      = 8;
   localparam int CNT_W        = $clog2(MAX_ITEMS + 1);
   localparam int K_W          = $clog2(TOP_SLOTS + 1);
   localparam int SLOT_W       = (TOP_SLOTS > 1) ? $clog2(TOP_SLOTS) : 1;

   localparam logic [LOGIT_W-1:0] INIT_VALUE = 32'h8000_0001;

   localparam int LCG_MUL      = 1103515245;
   localparam int LCG_ADD      = 12345;
   localparam int RAND_W       = 15;
   localparam int LCG_MUL_LO   = LCG_MUL % (2 ** RAND_W);

   localparam int FULL_WEIGHT  = 256;
   localparam int WEIGHT_SHIFT = 4;
   localparam int WEIGHT_W     = $clog2(FULL_WEIGHT + 1);
   localparam int TOTAL_W      = $clog2(TOP_SLOTS * FULL_WEIGHT + 1);

   typedef struct packed {
      logic [TOP_SLOTS-1:0][LOGIT_W-1:0] values;
      logic [TOP_SLOTS-1:0][POS_W-1:0]   positions;
      logic [SEED_W-1:0]                 seed;
      logic [K_W-1:0]                    k;
   } job_type;

endpackage

@@ design/topk_weighted_token_sampler_unit.sv @@
// topk_weighted_token_sampler_unit: top level of the top-k weighted token sampler
// instantiates tkws_front, tkws_queue and tkws_back; depends on tkws_pkg
//
// usage:
//   req_ channel: one signed logit per beat, req_last marks the final logit of a run;
//   req_seed is sampled on the last beat only. the insertion list takes one beat per
//   cycle; req_stall rises only while the two-entry job queue is full.
//   rsp_ channel: one beat per run, the run position of the sampled candidate.
//   csr_ channel: writes top_k (reset value 1, clamped to 1..8 on the last beat);
//   csr_ready is always high, write only while the block is idle.
// path: after its last beat a run passes the queue, the weights of its k slots,
//   the remainder loop over each bit of the random draw, a cumulative scan that can stop
//   early and the output register, with k the clamped top_k.
// throughput: one logit per cycle while req_stall is low; runs faster than the back
//   end are absorbed by the queue and then throttled to one run per selection.
// reset: synchronous, clears the list, the queue, the back-end state and the output valid flag.
// when rsp_stall is high the result holds in the output register, the back end waits
//   to hand over its next result, and the front accepts logits until the queue fills.

module topk_weighted_token_sampler_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [tkws_pkg::LOGIT_W-1:0] req_logit,
   input  logic [tkws_pkg::SEED_W-1:0]         req_seed,
   input  logic                                req_last,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [tkws_pkg::POS_W-1:0]          rsp_token_index,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tkws_pkg::TOP_K_W-1:0]        csr_top_k
);

   logic [tkws_pkg::TOP_K_W-1:0] top_k_ff, top_k_in;
   logic                         item_accept;
   logic                         q_push, q_full, q_valid, q_pop;
   tkws_pkg::job_type            q_push_job, q_pop_job;

   assign csr_ready   = 1'b1;
   assign top_k_in    = (csr_valid && csr_ready) ? csr_top_k : top_k_ff;
   assign req_stall   = q_full;
   assign item_accept = req_valid & ~req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         top_k_ff <= tkws_pkg::TOP_K_W'(1);
      end else begin
         top_k_ff <= top_k_in;
      end
   end

   tkws_front u_front (
      .clock       (clock),
      .reset       (reset),
      .item_accept (item_accept),
      .logit       (req_logit),
      .seed        (req_seed),
      .last        (req_last),
      .top_k       (top_k_ff),
      .push        (q_push),
      .push_job    (q_push_job)
   );

   tkws_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_push_job),
      .full     (q_full),
      .valid    (q_valid),
      .pop      (q_pop),
      .pop_job  (q_pop_job)
   );

   tkws_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_job           (q_pop_job),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_token_index (rsp_token_index)
   );

   // back end only takes a job that is there
   assert property (@(posedge clock) disable iff (reset) q_pop |-> q_valid)
      else $error("job taken from an empty queue");

   // a finished run is waiting in the queue the cycle after its last beat
   assert property (@(posedge clock) disable iff (reset) q_push |=> q_valid)
      else $error("finished run lost on its way to the queue");

   // nothing pending right after reset
   assert property (@(posedge clock) $past(reset) |-> (!rsp_valid && !q_valid))
      else $error("result or job pending after reset");

endmodule

@@ design/tkws_front.sv @@
// tkws_front: sorted top-k insertion list, one logit per beat
// hands a finished run to the job queue; depends on tkws_pkg

module tkws_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                item_accept,
   input  logic [tkws_pkg::LOGIT_W-1:0]        logit,
   input  logic [tkws_pkg::SEED_W-1:0]         seed,
   input  logic                                last,
   input  logic [tkws_pkg::TOP_K_W-1:0]        top_k,
   output logic                                push,
   output tkws_pkg::job_type                   push_job
);

   logic [tkws_pkg::TOP_SLOTS-1:0][tkws_pkg::LOGIT_W-1:0] values_ff, values_in, ins_values;
   logic [tkws_pkg::TOP_SLOTS-1:0][tkws_pkg::POS_W-1:0]   positions_ff, positions_in, ins_pos;
   logic [tkws_pkg::CNT_W-1:0]                            count_ff, count_in;
   logic [tkws_pkg::TOP_SLOTS-1:0]                        beats;
   logic [tkws_pkg::POS_W-1:0]                            cur_pos;
   logic [tkws_pkg::K_W-1:0]                              k_clamped;
   logic                                                  room;

   assign room    = count_ff < tkws_pkg::CNT_W'(tkws_pkg::MAX_ITEMS);
   assign cur_pos = tkws_pkg::POS_W'(count_ff);

   // list is non-increasing, so beats is a thermometer from the first smaller slot on
   always_comb begin
      for (int j = 0; j < tkws_pkg::TOP_SLOTS; j++) begin
         beats[j] = $signed(logit) > $signed(values_ff[j]);
      end
      ins_values[0] = beats[0] ? logit : values_ff[0];
      ins_pos[0]    = beats[0] ? cur_pos : positions_ff[0];
      for (int j = 1; j < tkws_pkg::TOP_SLOTS; j++) begin
         if (beats[j-1]) begin
            ins_values[j] = values_ff[j-1];
            ins_pos[j]    = positions_ff[j-1];
         end else if (beats[j]) begin
            ins_values[j] = logit;
            ins_pos[j]    = cur_pos;
         end else begin
            ins_values[j] = values_ff[j];
            ins_pos[j]    = positions_ff[j];
         end
      end
   end

   always_comb begin
      if (top_k == '0) begin
         k_clamped = tkws_pkg::K_W'(1);
      end else if (top_k > tkws_pkg::TOP_K_W'(tkws_pkg::TOP_SLOTS)) begin
         k_clamped = tkws_pkg::K_W'(tkws_pkg::TOP_SLOTS);
      end else begin
         k_clamped = tkws_pkg::K_W'(top_k);
      end
   end

   always_comb begin
      values_in    = values_ff;
      positions_in = positions_ff;
      count_in     = count_ff;
      if (item_accept) begin
         if (last) begin
            values_in    = {tkws_pkg::TOP_SLOTS{tkws_pkg::INIT_VALUE}};
            positions_in = '0;
            count_in     = '0;
         end else if (room) begin
            values_in    = ins_values;
            positions_in = ins_pos;
            count_in     = count_ff + tkws_pkg::CNT_W'(1);
         end
      end
   end

   assign push               = item_accept & last;
   assign push_job.values    = room ? ins_values : values_ff;
   assign push_job.positions = room ? ins_pos : positions_ff;
   assign push_job.seed      = seed;
   assign push_job.k         = k_clamped;

   always_ff @(posedge clock) begin
      if (reset) begin
         values_ff    <= {tkws_pkg::TOP_SLOTS{tkws_pkg::INIT_VALUE}};
         positions_ff <= '0;
         count_ff     <= '0;
      end else begin
         values_ff    <= values_in;
         positions_ff <= positions_in;
         count_ff     <= count_in;
      end
   end

endmodule

@@ design/tkws_queue.sv @@
// tkws_queue: short job queue between the insertion front and the selection back
// depends on tkws_pkg

module tkws_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tkws_pkg::job_type push_job,
   output logic              full,
   output logic              valid,
   input  logic              pop,
   output tkws_pkg::job_type pop_job
);

   localparam int PTR_W = (tkws_pkg::QUEUE_DEPTH > 1) ? $clog2(tkws_pkg::QUEUE_DEPTH) : 1;
   localparam int FILL_W = $clog2(tkws_pkg::QUEUE_DEPTH + 1);

   tkws_pkg::job_type entry_ff [tkws_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] result;
      if (ptr == PTR_W'(tkws_pkg::QUEUE_DEPTH - 1)) begin
         result = '0;
      end else begin
         result = ptr + PTR_W'(1);
      end
      return result;
   endfunction

   assign full    = fill_ff == FILL_W'(tkws_pkg::QUEUE_DEPTH);
   assign valid   = fill_ff != '0;
   assign pop_job = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + FILL_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

@@ design/tkws_back.sv @@
// tkws_back: weight, random draw and cumulative pick for one finished run
// sequencer over one slot or one remainder bit per cycle; depends on tkws_pkg

module tkws_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_valid,
   input  tkws_pkg::job_type           q_job,
   output logic                        q_pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [tkws_pkg::POS_W-1:0]  rsp_token_index
);

   localparam int BIT_W   = $clog2(tkws_pkg::RAND_W);
   localparam int DIFF_W  = tkws_pkg::LOGIT_W + 1;
   localparam int SHIFT_W = DIFF_W - 1 - tkws_pkg::WEIGHT_SHIFT;
   localparam int PROD_W  = tkws_pkg::SEED_W + tkws_pkg::RAND_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WEIGHT,
      ST_DIVIDE,
      ST_SCAN,
      ST_DONE
   } state_type;

   state_type                                               state_ff, state_in;
   tkws_pkg::job_type                                       job_ff, job_in;
   logic [tkws_pkg::TOP_SLOTS-1:0][tkws_pkg::WEIGHT_W-1:0]  weight_ff, weight_in;
   logic [tkws_pkg::TOTAL_W-1:0]                            total_ff, total_in;
   logic [tkws_pkg::TOTAL_W-1:0]                            rem_ff, rem_in;
   logic [tkws_pkg::TOTAL_W-1:0]                            cum_ff, cum_in;
   logic [tkws_pkg::RAND_W-1:0]                             dividend_ff, dividend_in;
   logic [BIT_W-1:0]                                        bit_ff, bit_in;
   logic [tkws_pkg::SLOT_W-1:0]                             slot_ff, slot_in;
   logic                                                    rsp_valid_ff, rsp_valid_in;
   logic [tkws_pkg::POS_W-1:0]                              rsp_index_ff, rsp_index_in;

   logic signed [DIFF_W-1:0]        diff;
   logic [SHIFT_W-1:0]              shifted;
   logic [tkws_pkg::WEIGHT_W-1:0]   weight_cur;
   logic [PROD_W-1:0]               lcg_prod;
   logic [tkws_pkg::RAND_W-1:0]     lcg_rand;
   logic [tkws_pkg::TOTAL_W:0]      trial;
   logic [tkws_pkg::TOTAL_W-1:0]    cum_next;
   logic                            last_slot;

   // only the low bits of the lcg matter, so a narrow multiplier does
   assign lcg_prod = PROD_W'(q_job.seed) * PROD_W'(tkws_pkg::LCG_MUL_LO);
   assign lcg_rand = lcg_prod[tkws_pkg::RAND_W-1:0] + tkws_pkg::RAND_W'(tkws_pkg::LCG_ADD);

   // weight of the current slot against the top value, clamped to 1..256
   always_comb begin
      diff = $signed({job_ff.values[0][tkws_pkg::LOGIT_W-1], job_ff.values[0]})
           - $signed({job_ff.values[slot_ff][tkws_pkg::LOGIT_W-1], job_ff.values[slot_ff]});
      shifted = diff[DIFF_W-1] ? '0 : diff[DIFF_W-2:tkws_pkg::WEIGHT_SHIFT];
      if (shifted >= SHIFT_W'(tkws_pkg::FULL_WEIGHT - 1)) begin
         weight_cur = tkws_pkg::WEIGHT_W'(1);
      end else begin
         weight_cur = tkws_pkg::WEIGHT_W'(tkws_pkg::FULL_WEIGHT)
                    - tkws_pkg::WEIGHT_W'(shifted);
      end
   end

   assign last_slot = tkws_pkg::K_W'(slot_ff) == job_ff.k - tkws_pkg::K_W'(1);
   assign trial     = {rem_ff, dividend_ff[tkws_pkg::RAND_W-1]};
   assign cum_next  = cum_ff + tkws_pkg::TOTAL_W'(weight_ff[slot_ff]);

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      weight_in    = weight_ff;
      total_in     = total_ff;
      rem_in       = rem_ff;
      cum_in       = cum_ff;
      dividend_in  = dividend_ff;
      bit_in       = bit_ff;
      slot_in      = slot_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_index_in = rsp_index_ff;
      q_pop        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop       = 1'b1;
               job_in      = q_job;
               slot_in     = '0;
               total_in    = '0;
               dividend_in = lcg_rand;
               state_in    = ST_WEIGHT;
            end
         end
         ST_WEIGHT: begin
            weight_in[slot_ff] = weight_cur;
            total_in           = total_ff + tkws_pkg::TOTAL_W'(weight_cur);
            if (last_slot) begin
               rem_in   = '0;
               bit_in   = '0;
               state_in = ST_DIVIDE;
            end else begin
               slot_in = slot_ff + tkws_pkg::SLOT_W'(1);
            end
         end
         ST_DIVIDE: begin
            // restoring remainder, one dividend bit per cycle
            if (trial >= {1'b0, total_ff}) begin
               rem_in = tkws_pkg::TOTAL_W'(trial - {1'b0, total_ff});
            end else begin
               rem_in = tkws_pkg::TOTAL_W'(trial);
            end
            dividend_in = dividend_ff << 1;
            bit_in      = bit_ff + BIT_W'(1);
            if (bit_ff == BIT_W'(tkws_pkg::RAND_W - 1)) begin
               slot_in  = '0;
               cum_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cum_in = cum_next;
            if (rem_ff < cum_next || last_slot) begin
               state_in = ST_DONE;
            end else begin
               slot_in = slot_ff + tkws_pkg::SLOT_W'(1);
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = job_ff.positions[slot_ff];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      job_ff       <= job_in;
      weight_ff    <= weight_in;
      total_ff     <= total_in;
      rem_ff       <= rem_in;
      cum_ff       <= cum_in;
      dividend_ff  <= dividend_in;
      bit_ff       <= bit_in;
      slot_ff      <= slot_in;
      rsp_index_ff <= rsp_index_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_token_index = rsp_index_ff;

endmodule
